// ===== sv/ctf_pkg.sv =====
// ---------------------------------------------------------------------------
// ctf_pkg
// Shared types and constants of the complementary tilt filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctf_pkg;

  // CORDIC datapath and angle widths
  localparam int CW           = 34;
  localparam int AW           = 26;
  localparam int ATAN_ENTRIES = 24;
  localparam int IDX_W        = 5;

  // Gyro step divide by 125: numerator 8*|rate*period|+62, quotient width
  localparam int DIV_NW = 43;
  localparam int DIV_QW = 36;
  // Reciprocals of 125: floor(2^32/125) for the estimate, ceil(2^24/125) for the remainder
  localparam logic [25:0] RECIP_HI = 26'd34359738;
  localparam logic [17:0] RECIP_LO = 18'd134218;

  localparam logic signed [AW-1:0] DEG180_Q16   = 26'sd11796480;
  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
  localparam logic [16:0]          ONE_Q16      = 17'd65536;

  // Configuration register indexes
  typedef enum logic {
    CFG_PERIOD = 1'b0,
    CFG_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
  } out_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117305;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/complementary_tilt_filter.sv =====
// ---------------------------------------------------------------------------
// complementary_tilt_filter
// Pitch/roll complementary filter with CORDIC tilt and gyro integration.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one IMU request: accel x/y/z counts and
//   gyro rates about x and y. out_valid/out_ready/out_data return the new
//   pitch and roll in Q15.16 degrees, one result per request.
//   cfg_we/cfg_index/cfg_data write period_ms (index 0) and blend_weight
//   (index 1); write only while the block is idle.
// Sequence:
//   The CORDIC runs CORDIC_ITERATIONS iterations, capped at 24. in_ready
//   rises together with out_valid, so a new request is taken only after
//   the previous one has finished. The gyro step division runs beside the
//   roll CORDIC pass; the pitch pass follows the roll pass on the same
//   CORDIC unit; the blend runs on one shared multiplier. in_ready is high
//   only between requests.
// Reset: estimates clear to zero, period to 0, weight to 6554, no result.
// Stall: the result register holds until out_ready; a new request is taken
//   meanwhile but finishes only after the pending result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module complementary_tilt_filter import ctf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int ITERS = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                            : CORDIC_ITERATIONS;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MULX, S_DIVST, S_WROLL, S_MAG, S_PST, S_WPITCH,
    S_BP1, S_BP2, S_BP3, S_BR1, S_BR2, S_BR3, S_FIN
  } state_t;

  state_t             state_r;
  in_t                in_r;
  logic [15:0]        period_r;
  logic [16:0]        weight_r;
  logic signed [31:0] pitch_est_r, roll_est_r, pitch_new_r;
  logic               out_valid_r;
  logic signed [70:0] prod_r, acc_r;
  logic [DIV_NW-1:0]  numy_r;
  logic               negy_r, negx_r, pitch_zero_r;
  logic signed [AW-1:0] roll_acc_r, pitch_acc_r;
  logic signed [37:0] gyro_p_r, gyro_r_r;

  // Shared multiplier operands
  logic signed [38:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [70:0] mul_p;

  logic [16:0]        w_eff, w_inv;
  logic               cor_start, cor_busy, div_busy;
  logic signed [CW-1:0] cor_x_in, cor_y_in, cor_x;
  logic signed [AW-1:0] cor_ang;
  logic [DIV_QW-1:0]  quo_y, quo_x;
  logic [DIV_NW-1:0]  num_prod;
  logic [39:0]        prod_mag;
  logic signed [CW-1:0] az_sc, ay_sc, ax_sc;
  logic               roll_neg, roll_zero;
  logic signed [AW-1:0] roll_off;
  logic signed [36:0] delta_y, delta_x;
  logic signed [70:0] blend_sum;
  logic signed [54:0] blend_sh;

  function automatic logic signed [31:0] sat32(input logic signed [54:0] v);
    logic signed [31:0] r;
    if (v > 55'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -55'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign w_eff = (weight_r > ONE_Q16) ? ONE_Q16 : weight_r;
  assign w_inv = ONE_Q16 - w_eff;

  // Scale accel counts by 2^14
  assign ax_sc = CW'(in_r.accel_x) <<< 14;
  assign ay_sc = CW'(in_r.accel_y) <<< 14;
  assign az_sc = CW'(in_r.accel_z) <<< 14;

  // Roll vector into the right half plane
  assign roll_neg  = in_r.accel_z[15];
  assign roll_zero = (in_r.accel_z == '0) && (in_r.accel_y == '0);
  assign roll_off  = !roll_neg ? '0 : (in_r.accel_y[15] ? -DEG180_Q16 : DEG180_Q16);

  always_comb begin
    cor_start = 1'b0;
    cor_x_in  = '0;
    cor_y_in  = '0;
    if (state_r == S_PREP) begin
      cor_start = 1'b1;
      cor_x_in  = roll_neg ? -az_sc : az_sc;
      cor_y_in  = roll_neg ? -ay_sc : ay_sc;
    end else if (state_r == S_PST) begin
      cor_start = 1'b1;
      cor_x_in  = CW'($signed({1'b0, prod_r[61:30]}));
      cor_y_in  = -ax_sc;
    end
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PREP: begin
        mul_a = 39'(in_r.rate_y);
        mul_b = 32'($signed({1'b0, period_r}));
      end
      S_MULX: begin
        mul_a = 39'(in_r.rate_x);
        mul_b = 32'($signed({1'b0, period_r}));
      end
      S_MAG: begin
        mul_a = 39'($signed({1'b0, INV_GAIN_Q30}));
        mul_b = cor_x[31:0];
      end
      S_BP1: begin
        mul_a = 39'(gyro_p_r);
        mul_b = 32'($signed({1'b0, w_inv}));
      end
      S_BP2: begin
        mul_a = 39'(pitch_acc_r);
        mul_b = 32'($signed({1'b0, w_eff}));
      end
      S_BR1: begin
        mul_a = 39'(gyro_r_r);
        mul_b = 32'($signed({1'b0, w_inv}));
      end
      S_BR2: begin
        mul_a = 39'(roll_acc_r);
        mul_b = 32'($signed({1'b0, w_eff}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider numerator: 8*|rate*period| + 62
  assign prod_mag = prod_r[70] ? 40'(-prod_r) : prod_r[39:0];
  assign num_prod = {prod_mag, 3'b000} + DIV_NW'(62);

  assign delta_y = negy_r ? -37'($signed({1'b0, quo_y})) : 37'($signed({1'b0, quo_y}));
  assign delta_x = negx_r ? -37'($signed({1'b0, quo_x})) : 37'($signed({1'b0, quo_x}));

  assign blend_sum = acc_r + prod_r + 71'sd32768;
  assign blend_sh  = 55'(blend_sum >>> 16);

  ctf_cordic #(.ITERS(ITERS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .x_in    (cor_x_in),
    .y_in    (cor_y_in),
    .busy    (cor_busy),
    .x_out   (cor_x),
    .ang_out (cor_ang)
  );

  ctf_gdiv u_gdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVST),
    .num_a (numy_r),
    .num_b (num_prod),
    .busy  (div_busy),
    .quo_a (quo_y),
    .quo_b (quo_x)
  );

  // Sequencer, estimates and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= '0;
      weight_r    <= 17'd6554;
      pitch_est_r <= '0;
      roll_est_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PERIOD: period_r <= cfg_data[15:0];
          CFG_WEIGHT: weight_r <= cfg_data;
        endcase
      end
      // Drop the taken result unless a new one replaces it this cycle
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          prod_r  <= mul_p;
          state_r <= S_MULX;
        end
        S_MULX: begin
          numy_r  <= num_prod;
          negy_r  <= prod_r[70];
          prod_r  <= mul_p;
          state_r <= S_DIVST;
        end
        S_DIVST: begin
          negx_r  <= prod_r[70];
          state_r <= S_WROLL;
        end
        S_WROLL: begin
          if (!cor_busy) begin
            roll_acc_r <= roll_zero ? '0 : roll_off + cor_ang;
            state_r    <= S_MAG;
          end
        end
        S_MAG: begin
          prod_r  <= mul_p;
          state_r <= S_PST;
        end
        S_PST: begin
          pitch_zero_r <= (prod_r[61:30] == '0) && (in_r.accel_x == '0);
          state_r      <= S_WPITCH;
        end
        S_WPITCH: begin
          if (!cor_busy && !div_busy) begin
            pitch_acc_r <= pitch_zero_r ? '0 : cor_ang;
            gyro_p_r    <= 38'(pitch_est_r) + 38'(delta_y);
            gyro_r_r    <= 38'(roll_est_r) + 38'(delta_x);
            state_r     <= S_BP1;
          end
        end
        S_BP1: begin
          prod_r  <= mul_p;
          state_r <= S_BP2;
        end
        S_BP2: begin
          acc_r   <= prod_r;
          prod_r  <= mul_p;
          state_r <= S_BP3;
        end
        S_BP3: begin
          pitch_new_r <= sat32(blend_sh);
          state_r     <= S_BR1;
        end
        S_BR1: begin
          prod_r  <= mul_p;
          state_r <= S_BR2;
        end
        S_BR2: begin
          acc_r   <= prod_r;
          prod_r  <= mul_p;
          state_r <= S_BR3;
        end
        S_BR3: begin
          roll_est_r <= sat32(blend_sh);
          state_r    <= S_FIN;
        end
        S_FIN: begin
          // Commit once the previous result has been taken
          if (!out_valid_r || out_ready) begin
            pitch_est_r <= pitch_new_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Roll commits early into its own register; hold the shown value stable
  out_t out_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_hold_r.pitch_angle <= pitch_new_r;
      out_hold_r.roll_angle  <= roll_est_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_hold_r;

endmodule

// ===== sv/ctf_cordic.sv =====
// ---------------------------------------------------------------------------
// ctf_cordic
// Vectoring CORDIC, one micro-rotation per cycle on a shared adder set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctf_cordic import ctf_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic                 busy,
  output logic signed [CW-1:0] x_out,
  output logic signed [AW-1:0] ang_out
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ITERS - 1);

  logic                 busy_r;
  logic [IDX_W-1:0]     idx_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [AW-1:0] ang_r;
  logic signed [CW-1:0] dx, dy;
  logic signed [AW-1:0] step_ang;

  assign dx       = y_r >>> idx_r;
  assign dy       = x_r >>> idx_r;
  assign step_ang = AW'($signed({1'b0, atan_q16(idx_r)}));

  // Control: run ITERS steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: rotate toward the x axis
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x_in;
      y_r   <= y_in;
      ang_r <= '0;
    end else if (busy_r) begin
      if (!y_r[CW-1]) begin
        x_r   <= x_r + dx;
        y_r   <= y_r - dy;
        ang_r <= ang_r + step_ang;
      end else begin
        x_r   <= x_r - dx;
        y_r   <= y_r + dy;
        ang_r <= ang_r - step_ang;
      end
    end
  end

  assign busy    = busy_r;
  assign x_out   = x_r;
  assign ang_out = ang_r;

endmodule

// ===== sv/ctf_gdiv.sv =====
// ---------------------------------------------------------------------------
// ctf_gdiv
// Two-lane divider by 125 on one reciprocal multiplier, one lane after the other.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctf_gdiv import ctf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num_a,
  input  logic [DIV_NW-1:0] num_b,
  output logic              busy,
  output logic [DIV_QW-1:0] quo_a,
  output logic [DIV_QW-1:0] quo_b
);

  typedef enum logic [1:0] {
    G_EST, G_REM, G_FINE, G_SUM
  } gstep_t;

  gstep_t            step_r;
  logic              busy_r;
  logic              lane_r;
  logic [DIV_NW-1:0] n_r [2];
  logic [DIV_QW-1:0] q_r [2];
  logic [DIV_QW-1:0] est_r;
  logic [16:0]       rem_r;
  logic [57:0]       prod_r;

  logic [DIV_NW-1:0] n_cur;
  logic [31:0]       mul_a;
  logic [25:0]       mul_b;
  logic [57:0]       mul_p;
  logic [DIV_QW-1:0] est;
  logic [DIV_NW-1:0] est_x125;
  logic [DIV_NW-1:0] rem_full;

  assign n_cur = n_r[lane_r];

  // Coarse estimate from the top bits, then the exact remainder quotient
  always_comb begin
    if (step_r == G_EST) begin
      mul_a = n_cur[DIV_NW-1:11];
      mul_b = RECIP_HI;
    end else begin
      mul_a = 32'(rem_r);
      mul_b = 26'(RECIP_LO);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Estimate never exceeds the quotient; what is left stays below 2^17
  assign est      = prod_r[56:21];
  assign est_x125 = (DIV_NW'(est) << 7) - (DIV_NW'(est) << 1) - DIV_NW'(est);
  assign rem_full = n_cur - est_x125;

  // Sequence both lanes through the multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      lane_r <= 1'b0;
      step_r <= G_EST;
    end else if (start) begin
      busy_r <= 1'b1;
      lane_r <= 1'b0;
      step_r <= G_EST;
      n_r[0] <= num_a;
      n_r[1] <= num_b;
    end else if (busy_r) begin
      unique case (step_r)
        G_EST: begin
          prod_r <= mul_p;
          step_r <= G_REM;
        end
        G_REM: begin
          est_r  <= est;
          rem_r  <= rem_full[16:0];
          step_r <= G_FINE;
        end
        G_FINE: begin
          prod_r <= mul_p;
          step_r <= G_SUM;
        end
        G_SUM: begin
          q_r[lane_r] <= est_r + DIV_QW'(prod_r[34:24]);
          step_r      <= G_EST;
          lane_r      <= 1'b1;
          if (lane_r) begin
            busy_r <= 1'b0;
          end
        end
      endcase
    end
  end

  assign busy  = busy_r;
  assign quo_a = q_r[0];
  assign quo_b = q_r[1];

endmodule

// ===== sv/ctf_chk.sv =====
// ---------------------------------------------------------------------------
// ctf_chk
// Port-level checks of the complementary tilt filter, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctf_chk import ctf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_t         in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_t        out_data,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [16:0] cfg_data
);

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Block goes busy after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  // A result never appears the cycle after a request
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind complementary_tilt_filter ctf_chk u_ctf_chk (.*);
